[hdl/lud_pkg.sv]
// Shared types and constants for the lenient UTF-8 decoder.
// No dependencies; compiled first.
`default_nettype none

package lud_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Result queue; depth must be a power of two so pointers wrap naturally
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Number of continuation bytes still expected for an open sequence
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // Byte class masks and patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD2_DATA = 8'h1F;
    localparam logic [7:0] LEAD3_DATA = 8'h0F;
    localparam logic [7:0] LEAD4_DATA = 8'h07;
    localparam logic [7:0] CONT_DATA  = 8'h3F;

    // One decoded character
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            final_char;
    } t_result;

endpackage

`default_nettype wire

[hdl/lud_if.sv]
// Valid/ready channel interfaces for the lenient UTF-8 decoder.
// Depends on lud_pkg for field widths.
`default_nettype none

interface lud_byte_if;
    logic                       valid;
    logic                       ready;
    logic [lud_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface lud_char_if;
    logic                     valid;
    logic                     ready;
    logic [lud_pkg::CP_W-1:0] code_point;
    logic                     final_char;

    modport source (output valid, output code_point, output final_char, input ready);
    modport sink   (input valid, input code_point, input final_char, output ready);
endinterface

`default_nettype wire

[hdl/lenient_utf8_decoder.sv]
// Lenient UTF-8 decoder: byte stream in, code points out through a small result queue.
// Depends on lud_pkg and the channel interfaces in lud_if.sv.
//
//   channel   direction  per transfer
//   i_byte    in         data_byte[7:0], end_of_string
//   o_char    out        code_point[20:0], final_char
//
// One byte is decoded in the cycle it is taken; its zero, one or two results
// enter a 4-entry result queue, which gives one character per cycle to a ready sink.
// A byte is taken whenever the queue has room for two results, so bytes flow
// at one per cycle as long as the sink keeps up with the characters they give.
// First result is visible the cycle after its byte transfer if the queue was empty.
// Reset (i_rst_n low, synchronous) closes any open sequence and empties the queue.
`default_nettype none

module lenient_utf8_decoder (
    input  wire     i_clk,
    input  wire     i_rst_n,
    lud_byte_if.sink   i_byte,
    lud_char_if.source o_char
);
    import lud_pkg::*;

    // Decoder state
    logic [CP_W-1:0]   r_partial, n_partial;
    logic [1:0]        r_pending, n_pending;

    // Result queue
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    logic              s_acc, s_pop, s_cont;
    logic [1:0]        s_push_cnt;
    t_result           s_res0, s_res1;
    logic [7:0]        s_lead_val;
    logic [1:0]        s_lead_extra;
    logic [7:0]        s_b;
    logic              s_eos;
    logic [1:0]        s_pend_dec;
    logic [CP_W-1:0]   s_shifted;
    logic [QPTR_W-1:0] s_wr1;

    assign s_b    = i_byte.data_byte;
    assign s_eos  = i_byte.end_of_string;
    assign s_cont = (s_b & CONT_MASK) == CONT_PAT;

    // Take a byte only when two results would still fit
    assign i_byte.ready = r_count <= QCNT_W'(QDEPTH - 2);
    assign s_acc        = i_byte.valid && i_byte.ready;
    assign s_pop        = o_char.valid && o_char.ready;

    // Classify a fresh byte
    always_comb begin
        priority if (!s_b[7]) begin
            s_lead_val   = s_b;
            s_lead_extra = PEND_NONE;
        end else if ((s_b & LEAD2_MASK) == LEAD2_PAT) begin
            s_lead_val   = s_b & LEAD2_DATA;
            s_lead_extra = PEND_ONE;
        end else if ((s_b & LEAD3_MASK) == LEAD3_PAT) begin
            s_lead_val   = s_b & LEAD3_DATA;
            s_lead_extra = PEND_TWO;
        end else if ((s_b & LEAD4_MASK) == LEAD4_PAT) begin
            s_lead_val   = s_b & LEAD4_DATA;
            s_lead_extra = PEND_THREE;
        end else begin
            s_lead_val   = s_b;
            s_lead_extra = PEND_NONE;
        end
    end

    assign s_shifted  = {r_partial[CP_W-7:0], 6'(s_b & CONT_DATA)};
    assign s_pend_dec = r_pending - 2'd1;

    // Work out the results and the next decoder state for this byte
    always_comb begin
        n_partial  = r_partial;
        n_pending  = r_pending;
        s_push_cnt = 2'd0;
        s_res0     = '{code_point: r_partial, final_char: 1'b0};
        s_res1     = '{code_point: CP_W'(s_lead_val), final_char: s_eos};
        if (r_pending != PEND_NONE && s_cont) begin
            // Continuation: gather six bits, close on last byte or end of string
            s_res0 = '{code_point: s_shifted, final_char: s_eos};
            if (s_pend_dec == PEND_NONE || s_eos) begin
                s_push_cnt = 2'd1;
                n_partial  = '0;
                n_pending  = PEND_NONE;
            end else begin
                n_partial  = s_shifted;
                n_pending  = s_pend_dec;
            end
        end else begin
            // Flush an interrupted sequence ahead of the fresh byte
            if (r_pending != PEND_NONE) begin
                s_push_cnt = 2'd1;
            end
            if (s_lead_extra == PEND_NONE || s_eos) begin
                if (r_pending != PEND_NONE) begin
                    s_push_cnt = 2'd2;
                end else begin
                    s_push_cnt = 2'd1;
                    s_res0     = s_res1;
                end
                n_partial = '0;
                n_pending = PEND_NONE;
            end else begin
                n_partial = CP_W'(s_lead_val);
                n_pending = s_lead_extra;
            end
        end
    end

    assign s_wr1 = r_wr + QPTR_W'(1);

    // Hold decoder state and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= PEND_NONE;
            r_wr      <= '0;
            r_rd      <= '0;
            r_count   <= '0;
        end else begin
            if (s_acc) begin
                r_partial <= n_partial;
                r_pending <= n_pending;
                r_wr      <= r_wr + QPTR_W'(s_push_cnt);
            end
            if (s_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + (s_acc ? QCNT_W'(s_push_cnt) : QCNT_W'(0))
                               - QCNT_W'(s_pop);
        end
    end

    // Write results into the queue
    always_ff @(posedge i_clk) begin
        if (s_acc && s_push_cnt != 2'd0) begin
            r_q[r_wr] <= s_res0;
        end
        if (s_acc && s_push_cnt == 2'd2) begin
            r_q[s_wr1] <= s_res1;
        end
    end

    // Drive the head of the queue
    assign o_char.valid      = r_count != '0;
    assign o_char.code_point = r_q[r_rd].code_point;
    assign o_char.final_char = r_q[r_rd].final_char;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_eos_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_eos) |=> (r_pending == PEND_NONE && r_partial == '0))
        else $error("sequence left open after end of string");

    a_last_cont_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_pending == PEND_ONE && s_cont) |=> r_pending == PEND_NONE)
        else $error("sequence not closed by its last continuation byte");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_push_cnt != 2'd0) |=> o_char.valid)
        else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire
